/* rtl/core/tcsa_pkg.sv */
// ----------------------------------------------------------------------------
// tcsa_pkg
// Shared types and constants of the transposed convolution scatter accumulator.
// ----------------------------------------------------------------------------
package tcsa_pkg;

  localparam int GRID     = 32;
  localparam int CHANNELS = 16;

  localparam int ROW_W  = (GRID > 1) ? $clog2(GRID) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = 2 * ROW_W + CH_W;

  // divider operand widths: pixel index over input size
  localparam int DVD_W = 10;
  localparam int DVS_W = 6;
  localparam int CNT_W = $clog2(DVD_W + 1);

  // target coordinates: (K-1-a) + r*stride
  localparam int POS_W = 15;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_TAP  = 2'd2;

  localparam logic [1:0] REG_STRIDE = 2'd0;
  localparam logic [1:0] REG_KERNEL = 2'd1;
  localparam logic [1:0] REG_INPUT  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_TAP,
    S_DIV_PIX,
    S_CALC,
    S_RD,
    S_WAIT,
    S_CLEAR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/core/transposed_conv_scatter_accumulator_top.sv */
// ----------------------------------------------------------------------------
// transposed_conv_scatter_accumulator_top
// Scatter-accumulate of tap products into a GRID x GRID x CHANNELS store.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  in      | cmd tap_index pixel_index channel       | valid / stall
//          | product_value read_row read_col         |
//  out     | entry_value status                      | valid / stall
//  cfg     | index data (stride, kernel, input size) | valid / ready
//
//  Accumulate: two passes through the shared restoring divider (10 steps
//  plus done; tap by K, pixel by input size), then a read-modify-write.
//  Read: check, memory read, registered data, result.
//  Clear and reset: a clearing pass writes one entry a cycle, all 16384
//  entries; no request is taken during it, configuration writes always are.
//  A result waits in the output register while out_stall is high; the next
//  request is taken only when the sequencer is back in idle.
//
module transposed_conv_scatter_accumulator_top
  import tcsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_tap_index,
  input  logic [9:0]         in_pixel_index,
  input  logic [3:0]         in_channel,
  input  logic signed [31:0] in_product_value,
  input  logic [4:0]         in_read_row,
  input  logic [4:0]         in_read_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_entry_value,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // configuration
  logic [3:0] stride_r;
  logic [3:0] kernel_r;
  logic [5:0] input_r;

  // latched request
  logic [1:0]         cmd_r;
  logic [7:0]         tap_r;
  logic [9:0]         pix_r;
  logic [3:0]         ch_r;
  logic signed [31:0] val_r;
  logic [4:0]         rrow_r;
  logic [4:0]         rcol_r;

  state_t state_r, state_nxt;

  logic [3:0]        a_r, a_nxt;
  logic [3:0]        b_r, b_nxt;
  logic [9:0]        r_r, r_nxt;
  logic [9:0]        c_r, c_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]       entry_r, entry_nxt;
  logic [1:0]        status_r, status_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_entry_value_r;
  logic [1:0]         out_status_r;
  logic               out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // memory
  logic [31:0]       mem [2**ADDR_W];
  logic [31:0]       rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] rw_addr;
  logic              in_grid;

  logic [7:0]  kk;
  logic [32:0] sum;
  logic [31:0] sat;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // register writes; unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= 4'd2;
      kernel_r <= 4'd3;
      input_r  <= 6'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STRIDE: stride_r <= cfg_data[3:0];
        REG_KERNEL: kernel_r <= cfg_data[3:0];
        REG_INPUT:  input_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // capture the request payload; the command resets to a non-clear code so
  // the clearing pass after reset ends in idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_ACC;
    end else if (in_valid && !in_stall) begin
      cmd_r <= in_cmd;
    end
    if (in_valid && !in_stall) begin
      tap_r  <= in_tap_index;
      pix_r  <= in_pixel_index;
      ch_r   <= in_channel;
      val_r  <= in_product_value;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
  end

  tcsa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // entry address from the held target, valid only when in_grid
  assign in_grid = (row_r < POS_W'(GRID)) && (col_r < POS_W'(GRID))
                && (32'(ch_r) < CHANNELS);
  assign rw_addr = {row_r[ROW_W-1:0], col_r[ROW_W-1:0], CH_W'(ch_r)};

  always_comb begin
    kk  = 8'(kernel_r * kernel_r);
    sum = {rd_data_r[31], rd_data_r} + {val_r[31], val_r};
    // clamp on signed overflow
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = sum[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    clr_cnt_nxt = clr_cnt_r;
    entry_nxt   = entry_r;
    status_nxt  = status_r;
    div_req     = '0;
    mem_we      = 1'b0;
    mem_waddr   = rw_addr;
    mem_wdata   = sat;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        entry_nxt  = '0;
        status_nxt = ST_OK;
        case (cmd_r)
          CMD_ACC: begin
            if (tap_r >= kk) begin
              status_nxt = ST_TAP;
              state_nxt  = S_FIN;
            end else if (input_r == '0) begin
              status_nxt = ST_DROP;
              state_nxt  = S_FIN;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DVD_W'(tap_r);
              div_req.divisor  = DVS_W'(kernel_r);
              state_nxt        = S_DIV_TAP;
            end
          end
          CMD_READ: begin
            row_nxt   = POS_W'(rrow_r);
            col_nxt   = POS_W'(rcol_r);
            state_nxt = S_RD;
          end
          CMD_CLEAR: begin
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DIV_TAP: begin
        if (div_rsp.done) begin
          a_nxt            = div_rsp.quo[3:0];
          b_nxt            = div_rsp.rem[3:0];
          div_req.start    = 1'b1;
          div_req.dividend = pix_r;
          div_req.divisor  = input_r;
          state_nxt        = S_DIV_PIX;
        end
      end
      S_DIV_PIX: begin
        if (div_rsp.done) begin
          r_nxt     = div_rsp.quo;
          c_nxt     = 10'(div_rsp.rem);
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        // a and b stay below K, so K-1-a does not wrap
        row_nxt   = POS_W'(kernel_r - 4'd1 - a_r) + POS_W'(r_r * stride_r);
        col_nxt   = POS_W'(kernel_r - 4'd1 - b_r) + POS_W'(c_r * stride_r);
        state_nxt = S_RD;
      end
      S_RD: begin
        if (in_grid) begin
          state_nxt = S_WAIT;
        end else begin
          status_nxt = ST_DROP;
          state_nxt  = S_FIN;
        end
      end
      S_WAIT: begin
        if (cmd_r == CMD_READ) begin
          entry_nxt = rd_data_r;
        end else begin
          mem_we = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = (cmd_r == CMD_CLEAR) ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    entry_r  <= entry_nxt;
    status_r <= status_nxt;
  end

  // memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rw_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_entry_value_r <= entry_r;
      out_status_r      <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_entry_value_r;
  assign out_status      = out_status_r;

  // a taken request always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request taken but sequencer idle");

  // the store is written only by the update or the clearing pass
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WAIT || state_r == S_CLEAR))
    else $error("store written outside update or clear");

  // a result is loaded only from the finish state
  a_load_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_FIN))
    else $error("result loaded outside finish state");

  // divider answers only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV_TAP || state_r == S_DIV_PIX))
    else $error("divider done in unexpected state");

  // a shown result never carries the unused status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != 2'd3))
    else $error("invalid status on output");

endmodule

/* rtl/core/tcsa_divider.sv */
// ----------------------------------------------------------------------------
// tcsa_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcsa_divider
  import tcsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    fits     = (trial >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt  = fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      dvd_nxt  = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule
